FILE: hw/rtl/fcc_pkg.sv
package fcc_pkg;

  localparam logic [15:0] CrcPoly     = 16'h8408;
  localparam logic [7:0]  PosMax      = 8'hFF;
  localparam logic [7:0]  MinFrame    = 8'd6;
  // first position at which the byte leaving the delay line is crc payload
  localparam logic [7:0]  CrcStartPos = 8'd5;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusShort  = 2'd1,
    StatusCrcErr = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_ok;
    status_e     status;
    logic [15:0] computed_crc;
    logic [7:0]  frame_length;
  } out_item_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/fcc_crc_core.sv
module fcc_crc_core import fcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [15:0] crc_q, crc_d, crc_upd;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  dly_q [3];
  logic [7:0]  len;

  assign crc_upd = (pos_q >= CrcStartPos) ? crc_byte(crc_q, dly_q[2]) : crc_q;
  assign len     = (pos_q == PosMax) ? PosMax : pos_q + 8'd1;

  always_comb begin
    result_o.computed_crc = crc_upd;
    result_o.frame_length = len;
    if (len < MinFrame) begin
      result_o.frame_ok = 1'b0;
      result_o.status   = StatusShort;
    end else if (crc_upd == {dly_q[0], dly_q[1]}) begin
      // newest held byte is the crc high byte
      result_o.frame_ok = 1'b1;
      result_o.status   = StatusOk;
    end else begin
      result_o.frame_ok = 1'b0;
      result_o.status   = StatusCrcErr;
    end
  end

  always_comb begin
    if (item_i.last_byte) begin
      crc_d = '0;
      pos_d = '0;
    end else begin
      crc_d = crc_upd;
      pos_d = (pos_q == PosMax) ? PosMax : pos_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= '0;
      pos_q    <= '0;
      dly_q[0] <= '0;
      dly_q[1] <= '0;
      dly_q[2] <= '0;
    end else if (step_i) begin
      crc_q    <= crc_d;
      pos_q    <= pos_d;
      dly_q[0] <= item_i.data_byte;
      dly_q[1] <= dly_q[0];
      dly_q[2] <= dly_q[1];
    end
  end

  a_clear_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_byte |=> pos_q == '0 && crc_q == '0)
    else $error("frame state not cleared after last item");

  a_pos_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.last_byte |=> pos_q != '0)
    else $error("position did not advance");

  a_ok_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.frame_ok == (result_o.status == StatusOk))
    else $error("frame_ok disagrees with status");

  a_short_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.status == StatusShort |-> result_o.computed_crc == '0)
    else $error("short frame with nonzero crc");

endmodule

FILE: hw/rtl/frame_crc16_checker.sv
// channel  | direction | handshake             | payload
// in       | input     | in_valid_i/in_ready_o | in_item_i  (data_byte, last_byte)
// out      | output    | out_valid_o/out_ready_i | out_item_o (frame_ok, status, crc, length)
//
// one byte per cycle but for the stall below; a byte's crc update is a combinational xor tree
// out_valid_o is registered: set when the last byte leaves s1 and the result slot is free
// reset clears crc, position, delay line and both valid flags
// bytes keep flowing while a result waits; only a last byte waits for a free result slot
module frame_crc16_checker import fcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_q;
  logic      res_valid_q, res_valid_d;
  out_item_t res_q;
  out_item_t core_res;
  logic      res_free, s1_go, in_fire;

  assign res_free   = !res_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_q.last_byte || res_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;

  fcc_crc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_go),
    .item_i   (s1_q),
    .result_o (core_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (s1_go && s1_q.last_byte) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_item_i;
    end
    if (s1_go && s1_q.last_byte) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_go && s1_q.last_byte && res_valid_q && !out_ready_i))
    else $error("pending result overwritten");

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_q.last_byte && res_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_q.last_byte |=> res_valid_q)
    else $error("result missing after last item");

endmodule

FILE: dv/frame_crc16_checker_tb.sv
module frame_crc16_checker_tb;
  import fcc_pkg::*;

  typedef enum int {
    FillRandom,
    FillZero,
    FillOnes
  } fill_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  frame_crc16_checker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // predictor state
  logic [15:0] run_crc;
  logic [7:0]  seen_bytes;
  logic [7:0]  byte_pipe [3];
  out_item_t   pending_results [$];
  int unsigned mismatch_cnt;

  // handshake idling on both sides when set
  bit          idle_on;
  logic [7:0]  frame_q [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL frame_crc16_checker");
    $finish;
  end

  // reflected crc-16, bit-serial form
  function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CrcPoly;
    end
    return acc;
  endfunction

  function automatic void track_byte(in_item_t it);
    logic [7:0] pos_now;
    logic [7:0] crc_hi;
    logic [7:0] crc_lo;
    logic [7:0] len;
    out_item_t  res;
    pos_now = seen_bytes;
    crc_hi  = byte_pipe[0];
    crc_lo  = byte_pipe[1];
    // byte leaving the delay line is frame index pos - 3
    if (pos_now >= CrcStartPos) run_crc = crc16_update(run_crc, byte_pipe[2]);
    byte_pipe[2] = byte_pipe[1];
    byte_pipe[1] = byte_pipe[0];
    byte_pipe[0] = it.data_byte;
    if (!it.last_byte) begin
      if (seen_bytes != PosMax) seen_bytes = seen_bytes + 8'd1;
      return;
    end
    len = (pos_now == PosMax) ? PosMax : pos_now + 8'd1;
    res.computed_crc = run_crc;
    res.frame_length = len;
    if (len < MinFrame) begin
      res.frame_ok = 1'b0;
      res.status   = StatusShort;
    end else if (run_crc == {crc_hi, crc_lo}) begin
      res.frame_ok = 1'b1;
      res.status   = StatusOk;
    end else begin
      res.frame_ok = 1'b0;
      res.status   = StatusCrcErr;
    end
    pending_results = {pending_results, res};
    run_crc    = '0;
    seen_bytes = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      run_crc    = '0;
      seen_bytes = '0;
      byte_pipe  = '{default: '0};
    end else begin
      if (in_valid_i && in_ready_o) track_byte(in_item_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: ok=%0b status=%0d crc=%h len=%0d",
                 out_item_o.frame_ok, out_item_o.status, out_item_o.computed_crc,
                 out_item_o.frame_length);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_item_o.frame_ok !== want.frame_ok) begin
            $error("frame_ok: expected %0b, got %0b", want.frame_ok, out_item_o.frame_ok);
            mismatch_cnt++;
          end
          if (out_item_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item_o.status);
            mismatch_cnt++;
          end
          if (out_item_o.computed_crc !== want.computed_crc) begin
            $error("computed_crc: expected %h, got %h", want.computed_crc,
                   out_item_o.computed_crc);
            mismatch_cnt++;
          end
          if (out_item_o.frame_length !== want.frame_length) begin
            $error("frame_length: expected %0d, got %0d", want.frame_length,
                   out_item_o.frame_length);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // result side backpressure
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{data_byte: b, last_byte: last};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic build_frame(input int len, input fill_e fill);
    logic [15:0] crc;
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      case (fill)
        FillZero: frame_q = {frame_q, 8'h00};
        FillOnes: frame_q = {frame_q, 8'hFF};
        default:  frame_q = {frame_q, 8'($urandom_range(0, 255))};
      endcase
    end
    if (len >= int'(MinFrame)) begin
      crc = '0;
      for (int i = 2; i <= len - 4; i++) crc = crc16_update(crc, frame_q[i]);
      frame_q[len-3] = crc[7:0];
      frame_q[len-2] = crc[15:8];
    end
  endtask

  task automatic corrupt_frame();
    int unsigned idx;
    idx = $urandom_range(2, frame_q.size() - 2);
    frame_q[idx][$urandom_range(0, 7)] ^= 1'b1;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic test_short_frames();
    idle_on = 1'b1;
    // single byte frame, then the longest too-short frame
    send_byte(8'hFF, 1'b1);
    build_frame(5, FillZero);
    send_frame();
  endtask

  task automatic test_min_good_frames();
    idle_on = 1'b0;
    build_frame(6, FillOnes);
    send_frame();
    build_frame(6, FillZero);
    send_frame();
  endtask

  task automatic test_crc_mismatch();
    idle_on = 1'b1;
    build_frame(7, FillRandom);
    frame_q[5] ^= 8'h80;
    send_frame();
  endtask

  task automatic test_long_frames();
    // length counter saturates, crc keeps running
    idle_on = 1'b0;
    build_frame(255, FillRandom);
    send_frame();
    idle_on = 1'b1;
    build_frame(257, FillRandom);
    send_frame();
    // short frame right after: stale delay line must not leak into crc
    build_frame(4, FillRandom);
    send_frame();
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    sent = 0;
    while (sent < 310) begin
      idle_on = ($urandom_range(0, 4) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 70) begin
        build_frame($urandom_range(6, 20), FillRandom);
        send_frame();
        sent += frame_q.size();
      end else if (pick < 85) begin
        build_frame($urandom_range(6, 20), FillRandom);
        corrupt_frame();
        send_frame();
        sent += frame_q.size();
      end else if (pick < 95) begin
        build_frame($urandom_range(1, 5), FillRandom);
        send_frame();
        sent += frame_q.size();
      end else begin
        // loose bytes with random last flags
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        end
        sent += n;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    idle_on      = 1'b1;
    mismatch_cnt = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_short_frames();
    test_min_good_frames();
    test_crc_mismatch();
    test_random_frames();
    test_long_frames();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS frame_crc16_checker");
    end else begin
      $display("FAIL frame_crc16_checker");
    end
    $finish;
  end

endmodule
